// ===== rtl/mcconv_pkg.sv =====
// Shared types and constants for the multichannel convolution accumulate unit
`timescale 1ns / 1ps
`default_nettype none

package mcconv_pkg;

  // default geometry
  localparam int IMG_DIM_DEF = 14;
  localparam int KSIZE_DEF   = 5;
  localparam int MAX_CH_DEF  = 4;

  // field widths
  localparam int DW     = 16;
  localparam int SUM_W  = 48;
  localparam int POS_W  = 4;
  localparam int WIDX_W = 7;
  localparam int CFG_W  = 3;

  // channel count register value after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 3'd3;

  // item commands
  localparam logic CMD_WEIGHT = 1'b0;
  localparam logic CMD_PIXEL  = 1'b1;

  // result queue sizing
  localparam int OQ_DEPTH = 8;
  localparam int OQ_PW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // per-item control that rides along the datapath
  typedef struct packed {
    logic             wr;       // window position valid, partial sum gets written
    logic             push;     // last channel, result goes out
    logic             first;    // first channel, overwrite partial sum
    logic             lastpos;  // bottom-right corner of the output map
    logic [POS_W-1:0] oy;
    logic [POS_W-1:0] ox;
  } tag_t;

  // one result item
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic                    last;
  } res_t;

  // result queue occupancy
  typedef struct packed {
    logic [OQ_CW-1:0] cnt;
    logic [OQ_CW-1:0] used;
  } oq_stat_t;

endpackage

`default_nettype wire

// ===== rtl/mcconv_win.sv =====
// Raster position tracking, line memory and sliding window registers
`timescale 1ns / 1ps
`default_nettype none

module mcconv_win #(
  parameter int IMG_DIM      = mcconv_pkg::IMG_DIM_DEF,
  parameter int KSIZE        = mcconv_pkg::KSIZE_DEF,
  parameter int MAX_CHANNELS = mcconv_pkg::MAX_CH_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      pix_acc,
  input  wire logic signed [mcconv_pkg::DW-1:0]          data,
  input  wire logic [mcconv_pkg::CFG_W-1:0]              cfg_ch,
  output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] ch_o,
  output logic [KSIZE*KSIZE*mcconv_pkg::DW-1:0]          win_o,
  output mcconv_pkg::tag_t                               tag_o,
  output logic [(((IMG_DIM-KSIZE+1)*(IMG_DIM-KSIZE+1) > 1) ?
                 $clog2((IMG_DIM-KSIZE+1)*(IMG_DIM-KSIZE+1)) : 1)-1:0] pidx_o,
  output logic                                           reserve_o
);

  localparam int DW    = mcconv_pkg::DW;
  localparam int PSW   = mcconv_pkg::POS_W;
  localparam int RCW   = $clog2(IMG_DIM);
  localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NPOS  = (IMG_DIM - KSIZE + 1) * (IMG_DIM - KSIZE + 1);
  localparam int PW    = (NPOS > 1) ? $clog2(NPOS) : 1;
  localparam int LROWS = (KSIZE > 1) ? KSIZE - 1 : 1;
  localparam int LW    = LROWS * DW;

  logic [RCW-1:0]     row_r, row_nxt;
  logic [RCW-1:0]     col_r, col_nxt;
  logic [CHW-1:0]     ch_r, ch_nxt;
  logic [PW-1:0]      pidx_r, pidx_nxt;
  logic [PW-1:0]      pidx1_r;
  logic [CHW:0]       nch;
  logic               is_last;
  logic               col_end;
  logic               row_end;
  logic               win_ok;
  logic [RCW-1:0]     oy_full;
  logic [RCW-1:0]     ox_full;
  mcconv_pkg::tag_t   tag_r, tag_nxt;

  logic [LW-1:0]      line_mem [IMG_DIM];
  logic [LW-1:0]      line_q_r;
  logic [LW+DW-1:0]   line_cat;
  logic [LW-1:0]      line_new;

  logic signed [DW-1:0] win_r   [KSIZE][KSIZE];
  logic signed [DW-1:0] win_nxt [KSIZE][KSIZE];

  // effective channel count, clamped to 1..MAX_CHANNELS
  always_comb begin
    if (cfg_ch == '0) begin
      nch = (CHW+1)'(1);
    end else if (int'(cfg_ch) > MAX_CHANNELS) begin
      nch = (CHW+1)'(MAX_CHANNELS);
    end else begin
      nch = (CHW+1)'(cfg_ch);
    end
  end

  assign is_last = ((CHW+1)'(ch_r) + (CHW+1)'(1)) >= nch;
  assign col_end = (col_r == RCW'(IMG_DIM - 1));
  assign row_end = (row_r == RCW'(IMG_DIM - 1));
  assign win_ok  = (row_r >= RCW'(KSIZE - 1)) && (col_r >= RCW'(KSIZE - 1));
  assign oy_full = row_r - RCW'(KSIZE - 1);
  assign ox_full = col_r - RCW'(KSIZE - 1);

  // raster position, channel and output position counters
  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    ch_nxt   = ch_r;
    pidx_nxt = pidx_r;
    if (pix_acc) begin
      if (col_end) begin
        col_nxt = '0;
        if (row_end) begin
          row_nxt = '0;
          ch_nxt  = is_last ? '0 : ch_r + CHW'(1);
        end else begin
          row_nxt = row_r + RCW'(1);
        end
      end else begin
        col_nxt = col_r + RCW'(1);
      end
      if (win_ok) begin
        pidx_nxt = (row_end && col_end) ? '0 : pidx_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      ch_r   <= '0;
      pidx_r <= '0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      ch_r   <= ch_nxt;
      pidx_r <= pidx_nxt;
    end
  end

  // line memory column: older rows shift up, the new pixel enters the bottom lane
  assign line_cat = {data, line_q_r};
  assign line_new = line_cat[LW+DW-1:DW];

  // read address follows the next column so the column is ready when its pixel arrives
  always_ff @(posedge clk) begin
    if (pix_acc) begin
      line_mem[col_r] <= line_new;
    end
    line_q_r <= line_mem[col_nxt];
  end

  // window shifts left, new column from line memory plus the incoming pixel
  always_comb begin
    win_nxt = win_r;
    if (pix_acc) begin
      for (int kr = 0; kr < KSIZE; kr++) begin
        for (int kc = 0; kc < KSIZE - 1; kc++) begin
          win_nxt[kr][kc] = win_r[kr][kc+1];
        end
      end
      for (int kr = 0; kr < KSIZE - 1; kr++) begin
        win_nxt[kr][KSIZE-1] = line_q_r[kr*DW +: DW];
      end
      win_nxt[KSIZE-1][KSIZE-1] = data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '{default: '0};
    end else begin
      win_r <= win_nxt;
    end
  end

  // control for the item entering the datapath
  always_comb begin
    tag_nxt         = '0;
    tag_nxt.wr      = pix_acc && win_ok;
    tag_nxt.push    = pix_acc && win_ok && is_last;
    tag_nxt.first   = (ch_r == '0);
    tag_nxt.lastpos = row_end && col_end;
    tag_nxt.oy      = PSW'(oy_full);
    tag_nxt.ox      = PSW'(ox_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      pidx1_r <= pidx_r;
    end
  end

  // flatten window for the multiplier array
  always_comb begin
    for (int kr = 0; kr < KSIZE; kr++) begin
      for (int kc = 0; kc < KSIZE; kc++) begin
        win_o[(kr*KSIZE+kc)*DW +: DW] = win_r[kr][kc];
      end
    end
  end

  assign ch_o      = ch_r;
  assign tag_o     = tag_r;
  assign pidx_o    = pidx1_r;
  assign reserve_o = tag_nxt.push;

endmodule

`default_nettype wire

// ===== rtl/mcconv_mac.sv =====
// Weight memory and the pipelined multiply and adder tree over the window
`timescale 1ns / 1ps
`default_nettype none

module mcconv_mac #(
  parameter int IMG_DIM      = mcconv_pkg::IMG_DIM_DEF,
  parameter int KSIZE        = mcconv_pkg::KSIZE_DEF,
  parameter int MAX_CHANNELS = mcconv_pkg::MAX_CH_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      wt_acc,
  input  wire logic [mcconv_pkg::WIDX_W-1:0]             wt_idx,
  input  wire logic signed [mcconv_pkg::DW-1:0]          data,
  input  wire logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] rd_ch,
  input  wire logic [KSIZE*KSIZE*mcconv_pkg::DW-1:0]     win,
  input  wire mcconv_pkg::tag_t                          tag_i,
  input  wire logic [(((IMG_DIM-KSIZE+1)*(IMG_DIM-KSIZE+1) > 1) ?
                 $clog2((IMG_DIM-KSIZE+1)*(IMG_DIM-KSIZE+1)) : 1)-1:0] pidx_i,
  output logic signed [mcconv_pkg::SUM_W-1:0]            tot_o,
  output mcconv_pkg::tag_t                               tag_o,
  output logic [(((IMG_DIM-KSIZE+1)*(IMG_DIM-KSIZE+1) > 1) ?
                 $clog2((IMG_DIM-KSIZE+1)*(IMG_DIM-KSIZE+1)) : 1)-1:0] pidx_o
);

  localparam int DW    = mcconv_pkg::DW;
  localparam int SW    = mcconv_pkg::SUM_W;
  localparam int KK    = KSIZE * KSIZE;
  localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int LNW   = (KK > 1) ? $clog2(KK) : 1;
  localparam int NPOS  = (IMG_DIM - KSIZE + 1) * (IMG_DIM - KSIZE + 1);
  localparam int PW    = (NPOS > 1) ? $clog2(NPOS) : 1;
  localparam int PRW   = 2 * DW;
  localparam int RSW   = PRW + $clog2(KSIZE);
  localparam int TW    = RSW + $clog2(KSIZE);

  logic                 wr_ok;
  logic [CHW-1:0]       wr_ch;
  logic [LNW-1:0]       wr_lane;

  logic signed [DW-1:0]  wt_mem [MAX_CHANNELS][KK];
  logic signed [DW-1:0]  wq_r   [KK];
  logic signed [PRW-1:0] prod_r [KK];
  logic signed [RSW-1:0] rsum_r [KSIZE];
  logic signed [RSW-1:0] rsum_nxt [KSIZE];
  logic signed [TW-1:0]  tsum;
  logic signed [SW-1:0]  tot_r;

  mcconv_pkg::tag_t     tag2_r, tag3_r, tag4_r;
  logic [PW-1:0]        pidx2_r, pidx3_r, pidx4_r;

  // split weight index into channel row and kernel lane
  always_comb begin
    wr_ok   = int'(wt_idx) < MAX_CHANNELS * KK;
    wr_ch   = '0;
    wr_lane = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (int'(wt_idx) >= i * KK) begin
        wr_ch   = CHW'(i);
        wr_lane = LNW'(int'(wt_idx) - i * KK);
      end
    end
  end

  // one row per channel, lane write on load, whole row read per pixel
  always_ff @(posedge clk) begin
    if (wt_acc && wr_ok) begin
      wt_mem[wr_ch][wr_lane] <= data;
    end
    wq_r <= wt_mem[rd_ch];
  end

  // multiplier array
  always_ff @(posedge clk) begin
    for (int k = 0; k < KK; k++) begin
      prod_r[k] <= $signed(win[k*DW +: DW]) * wq_r[k];
    end
  end

  // row sums of the products
  always_comb begin
    for (int kr = 0; kr < KSIZE; kr++) begin
      rsum_nxt[kr] = '0;
      for (int kc = 0; kc < KSIZE; kc++) begin
        rsum_nxt[kr] = rsum_nxt[kr] + RSW'(prod_r[kr*KSIZE+kc]);
      end
    end
  end

  always_ff @(posedge clk) begin
    rsum_r <= rsum_nxt;
  end

  // window total
  always_comb begin
    tsum = '0;
    for (int kr = 0; kr < KSIZE; kr++) begin
      tsum = tsum + TW'(rsum_r[kr]);
    end
  end

  always_ff @(posedge clk) begin
    tot_r <= SW'(tsum);
  end

  // control follows the data through the three stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
      tag3_r <= '0;
      tag4_r <= '0;
    end else begin
      tag2_r <= tag_i;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
    end
  end

  always_ff @(posedge clk) begin
    pidx2_r <= pidx_i;
    pidx3_r <= pidx2_r;
    pidx4_r <= pidx3_r;
  end

  assign tot_o  = tot_r;
  assign tag_o  = tag4_r;
  assign pidx_o = pidx4_r;

endmodule

`default_nettype wire

// ===== rtl/mcconv_psum.sv =====
// Partial sum memory with read, accumulate and write back across channels
`timescale 1ns / 1ps
`default_nettype none

module mcconv_psum #(
  parameter int IMG_DIM = mcconv_pkg::IMG_DIM_DEF,
  parameter int KSIZE   = mcconv_pkg::KSIZE_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic signed [mcconv_pkg::SUM_W-1:0]       tot_i,
  input  wire mcconv_pkg::tag_t                          tag_i,
  input  wire logic [(((IMG_DIM-KSIZE+1)*(IMG_DIM-KSIZE+1) > 1) ?
                 $clog2((IMG_DIM-KSIZE+1)*(IMG_DIM-KSIZE+1)) : 1)-1:0] pidx_i,
  output logic                                           push_o,
  output mcconv_pkg::res_t                               res_o
);

  localparam int SW   = mcconv_pkg::SUM_W;
  localparam int NPOS = (IMG_DIM - KSIZE + 1) * (IMG_DIM - KSIZE + 1);
  localparam int PW   = (NPOS > 1) ? $clog2(NPOS) : 1;

  logic signed [SW-1:0] ps_mem [NPOS];
  logic signed [SW-1:0] psq_r;
  logic signed [SW-1:0] tot_r;
  logic signed [SW-1:0] acc;
  logic [PW-1:0]        pidx_r;
  mcconv_pkg::tag_t     tag_r;

  // earlier channels' total, overwritten on the first channel
  assign acc = tag_r.first ? tot_r : tot_r + psq_r;

  // the same entry comes back only one whole image later, so no forwarding
  always_ff @(posedge clk) begin
    psq_r <= ps_mem[pidx_i];
    if (tag_r.wr) begin
      ps_mem[pidx_r] <= acc;
    end
  end

  always_ff @(posedge clk) begin
    tot_r  <= tot_i;
    pidx_r <= pidx_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_i;
    end
  end

  // result item toward the output queue
  assign push_o    = tag_r.push;
  assign res_o.sum  = acc;
  assign res_o.row  = tag_r.oy;
  assign res_o.col  = tag_r.ox;
  assign res_o.last = tag_r.lastpos;

endmodule

`default_nettype wire

// ===== rtl/mcconv_outq.sv =====
// Result queue with slot reservation for items still in the pipeline
`timescale 1ns / 1ps
`default_nettype none

module mcconv_outq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           reserve,
  input  wire logic           push,
  input  wire mcconv_pkg::res_t res_i,
  input  wire logic           out_ready,
  output logic                out_valid,
  output mcconv_pkg::res_t    res_o,
  output logic                room,
  output mcconv_pkg::oq_stat_t stat_o
);

  localparam int PW = mcconv_pkg::OQ_PW;
  localparam int CW = mcconv_pkg::OQ_CW;

  mcconv_pkg::res_t oq_mem [mcconv_pkg::OQ_DEPTH];
  logic [PW-1:0]    head_r, head_nxt;
  logic [PW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    used_r, used_nxt;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign res_o     = oq_mem[head_r];
  assign room      = (used_r < CW'(mcconv_pkg::OQ_DEPTH));

  // pointers, stored count and reserved count
  always_comb begin
    head_nxt = pop ? head_r + PW'(1) : head_r;
    tail_nxt = push ? tail_r + PW'(1) : tail_r;
    cnt_nxt  = cnt_r + CW'(push) - CW'(pop);
    used_nxt = used_r + CW'(reserve) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      used_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      oq_mem[tail_r] <= res_i;
    end
  end

  assign stat_o.cnt  = cnt_r;
  assign stat_o.used = used_r;

endmodule

`default_nettype wire

// ===== rtl/multichannel_conv2d_accumulate_unit.sv =====
// Top level of the multichannel 2D convolution accumulate unit
// Usage:
// - input channel (in_*): each item is a weight load (in_cmd 0, in_weight_index,
//   in_data) or one pixel (in_cmd 1, in_data); pixels arrive in raster order as whole
//   images, one channel after another; load weights before the pixels that use them
// - cfg_we / cfg_wdata write the channel count; write only while the unit is idle
// - result channel (out_*): one item per valid window position of the last channel,
//   channel-summed, with out_last on the bottom-right corner of the output map
// - throughput: one item per cycle, weights and pixels alike, while in_ready is high
// - after its pixel is accepted, a result passes the weight row read, multiply,
//   row sums, total and partial sum read and write back before it becomes visible
// - an 8-entry result queue reserves a slot for every pixel that will produce a
//   result; when the receiver stalls the queue fills and in_ready drops, and it
//   rises again as results are taken
// - reset clears the raster position, channel counter, window and queue and sets
//   the channel count to 3; weights and partial sums hold nothing until written,
//   and there is no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module multichannel_conv2d_accumulate_unit #(
  parameter int IMG_DIM      = mcconv_pkg::IMG_DIM_DEF,
  parameter int KSIZE        = mcconv_pkg::KSIZE_DEF,
  parameter int MAX_CHANNELS = mcconv_pkg::MAX_CH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_cmd,
  input  wire logic [mcconv_pkg::WIDX_W-1:0]       in_weight_index,
  input  wire logic signed [mcconv_pkg::DW-1:0]    in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [mcconv_pkg::SUM_W-1:0]      out_sum,
  output logic [mcconv_pkg::POS_W-1:0]             out_row,
  output logic [mcconv_pkg::POS_W-1:0]             out_col,
  output logic                                     out_last,
  input  wire logic                                cfg_we,
  input  wire logic [mcconv_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int CHW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int OUT_DIM = IMG_DIM - KSIZE + 1;
  localparam int NPOS    = OUT_DIM * OUT_DIM;
  localparam int PW      = (NPOS > 1) ? $clog2(NPOS) : 1;
  localparam int PSW     = mcconv_pkg::POS_W;
  localparam logic [PSW-1:0] LAST_POS = PSW'(OUT_DIM - 1);

  logic [mcconv_pkg::CFG_W-1:0]        ch_cfg_r;
  logic                                in_acc;
  logic                                pix_acc;
  logic                                wt_acc;
  logic [CHW-1:0]                      cur_ch;
  logic [KSIZE*KSIZE*mcconv_pkg::DW-1:0] win;
  mcconv_pkg::tag_t                    tag1, tag4;
  logic [PW-1:0]                       pidx1, pidx4;
  logic signed [mcconv_pkg::SUM_W-1:0] tot4;
  logic                                reserve;
  logic                                push;
  mcconv_pkg::res_t                    res_in, res_out;
  mcconv_pkg::oq_stat_t                oq_stat;
  logic                                room;

  // channel count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_cfg_r <= mcconv_pkg::CFG_RESET;
    end else if (cfg_we) begin
      ch_cfg_r <= cfg_wdata;
    end
  end

  // input handshake and item decode
  assign in_ready = room;
  assign in_acc   = in_valid && in_ready;
  assign pix_acc  = in_acc && (in_cmd == mcconv_pkg::CMD_PIXEL);
  assign wt_acc   = in_acc && (in_cmd == mcconv_pkg::CMD_WEIGHT);

  mcconv_win #(
    .IMG_DIM      (IMG_DIM),
    .KSIZE        (KSIZE),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_acc   (pix_acc),
    .data      (in_data),
    .cfg_ch    (ch_cfg_r),
    .ch_o      (cur_ch),
    .win_o     (win),
    .tag_o     (tag1),
    .pidx_o    (pidx1),
    .reserve_o (reserve)
  );

  mcconv_mac #(
    .IMG_DIM      (IMG_DIM),
    .KSIZE        (KSIZE),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .wt_acc (wt_acc),
    .wt_idx (in_weight_index),
    .data   (in_data),
    .rd_ch  (cur_ch),
    .win    (win),
    .tag_i  (tag1),
    .pidx_i (pidx1),
    .tot_o  (tot4),
    .tag_o  (tag4),
    .pidx_o (pidx4)
  );

  mcconv_psum #(
    .IMG_DIM (IMG_DIM),
    .KSIZE   (KSIZE)
  ) u_psum (
    .clk    (clk),
    .rst_n  (rst_n),
    .tot_i  (tot4),
    .tag_i  (tag4),
    .pidx_i (pidx4),
    .push_o (push),
    .res_o  (res_in)
  );

  mcconv_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .reserve   (reserve),
    .push      (push),
    .res_i     (res_in),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_o     (res_out),
    .room      (room),
    .stat_o    (oq_stat)
  );

  // result fields
  assign out_sum  = res_out.sum;
  assign out_row  = res_out.row;
  assign out_col  = res_out.col;
  assign out_last = res_out.last;

`ifndef SYNTHESIS
  // stored results never exceed reserved slots
  a_cnt_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    oq_stat.cnt <= oq_stat.used)
    else $error("result queue holds more items than were reserved");

  // reservations stay within the queue
  a_used_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    int'(oq_stat.used) <= mcconv_pkg::OQ_DEPTH)
    else $error("result queue over-reserved");

  // a weight load never reserves a result slot
  a_wt_no_reserve: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_cmd == mcconv_pkg::CMD_WEIGHT))
    |=> (oq_stat.used <= $past(oq_stat.used)))
    else $error("weight item reserved a result slot");

  // the flagged result sits at the bottom-right corner
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> ((out_row == LAST_POS) && (out_col == LAST_POS)))
    else $error("last flag away from the final output position");
`endif

endmodule

`default_nettype wire

// ===== verif/window_sum_checker.sv =====
// Checker that predicts the channel-summed window sums and compares them with the unit's output
`timescale 1ns / 1ps

module window_sum_checker
  import mcconv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    in_cmd,
  input  logic [WIDX_W-1:0]       in_weight_index,
  input  logic signed [DW-1:0]    in_data,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [SUM_W-1:0] out_sum,
  input  logic [POS_W-1:0]        out_row,
  input  logic [POS_W-1:0]        out_col,
  input  logic                    out_last,
  input  logic                    cfg_we,
  input  logic [CFG_W-1:0]        cfg_wdata,
  output int                      mismatch_count,
  output int                      sums_pending,
  output int                      items_taken,
  output int                      sums_checked
);

  localparam int IMG  = IMG_DIM_DEF;
  localparam int K    = KSIZE_DEF;
  localparam int NCH  = MAX_CH_DEF;
  localparam int ODIM = IMG - K + 1;
  localparam int NW   = NCH * K * K;

  // shadow copy of the unit's storage
  logic signed [DW-1:0] coef_mem [NW];
  logic signed [DW-1:0] line_mem [K-1][IMG];
  logic signed [DW-1:0] win      [K][K];
  longint               acc_mem  [ODIM*ODIM];
  int                   prow;
  int                   pcol;
  int                   chan;
  logic [CFG_W-1:0]     chan_cfg;

  // window sums still owed by the unit, oldest first
  res_t expected_sums [$];

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic clear_state();
    prow = 0;
    pcol = 0;
    chan = 0;
    chan_cfg = CFG_RESET;
    for (int kr = 0; kr < K; kr++)
      for (int kc = 0; kc < K; kc++)
        win[kr][kc] = '0;
    for (int kr = 0; kr < K - 1; kr++)
      for (int c = 0; c < IMG; c++)
        line_mem[kr][c] = '0;
    expected_sums.delete();
  endtask

  // one accepted item: store a weight or slide the window and maybe owe a sum
  task automatic predict_window_sum(input logic cmd, input logic [WIDX_W-1:0] widx,
                                    input logic signed [DW-1:0] px);
    int     r;
    int     c;
    int     ch;
    int     nch;
    int     base;
    int     oy;
    int     ox;
    bit     last_ch;
    longint acc;
    res_t   item;
    if (cmd == CMD_WEIGHT) begin
      // indexes past the store are dropped
      if (widx < NW) coef_mem[widx] = px;
    end else begin
      r = prow;
      c = pcol;
      ch = chan;
      // zero acts as one, anything past the maximum as the maximum
      nch = (chan_cfg == 0) ? 1 : ((chan_cfg > NCH) ? NCH : int'(chan_cfg));
      last_ch = (ch + 1 >= nch);

      // slide the window left and pull in the new column
      for (int kr = 0; kr < K; kr++)
        for (int kc = 0; kc < K - 1; kc++)
          win[kr][kc] = win[kr][kc+1];
      for (int kr = 0; kr < K - 1; kr++)
        win[kr][K-1] = line_mem[kr][c];
      win[K-1][K-1] = px;

      // shift this column of the line store up
      for (int kr = 0; kr < K - 2; kr++)
        line_mem[kr][c] = line_mem[kr+1][c];
      line_mem[K-2][c] = px;

      // raster position and channel counter
      if (c + 1 >= IMG) begin
        pcol = 0;
        if (r + 1 >= IMG) begin
          prow = 0;
          chan = last_ch ? 0 : (ch + 1) % NCH;
        end else begin
          prow = r + 1;
        end
      end else begin
        pcol = c + 1;
      end

      // full window: accumulate into the partial sum, emit on the last channel
      if (r >= K - 1 && c >= K - 1) begin
        oy = r - (K - 1);
        ox = c - (K - 1);
        base = (ch % NCH) * K * K;
        acc = 0;
        for (int kr = 0; kr < K; kr++)
          for (int kc = 0; kc < K; kc++)
            acc += longint'(win[kr][kc]) * longint'(coef_mem[base + kr*K + kc]);
        if (ch != 0) acc += acc_mem[oy*ODIM + ox];
        acc_mem[oy*ODIM + ox] = acc;
        if (last_ch) begin
          item.sum  = acc[SUM_W-1:0];
          item.row  = POS_W'(oy);
          item.col  = POS_W'(ox);
          item.last = (oy == ODIM - 1 && ox == ODIM - 1);
          expected_sums.insert(expected_sums.size(), item);
        end
      end
    end
  endtask

  // compare one output item against the oldest owed sum
  task automatic check_sum();
    res_t want;
    if (expected_sums.size() == 0) begin
      report_mismatch($sformatf("sum %0d at row %0d col %0d with nothing owed",
                                out_sum, out_row, out_col));
    end else begin
      want = expected_sums.pop_front();
      sums_checked++;
      if (out_sum !== want.sum)
        report_mismatch($sformatf("row %0d col %0d: sum %0d, want %0d",
                                  want.row, want.col, out_sum, want.sum));
      if (out_row !== want.row)
        report_mismatch($sformatf("out_row %0d, want %0d", out_row, want.row));
      if (out_col !== want.col)
        report_mismatch($sformatf("out_col %0d, want %0d", out_col, want.col));
      if (out_last !== want.last)
        report_mismatch($sformatf("row %0d col %0d: out_last %0b, want %0b",
                                  want.row, want.col, out_last, want.last));
    end
  endtask

  // inputs before outputs so a sum never precedes its own pixel
  // an item taken at the same edge as a channel count write still sees the old count
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
    end else begin
      if (in_valid && in_ready) begin
        items_taken++;
        predict_window_sum(in_cmd, in_weight_index, in_data);
      end
      if (cfg_we) chan_cfg = cfg_wdata;
      if (out_valid && out_ready) check_sum();
    end
    sums_pending = expected_sums.size();
  end

endmodule

// ===== verif/multichannel_conv2d_accumulate_unit_test.sv =====
// Testbench top for the multichannel convolution accumulate unit: stimulus, stalls and verdict
`timescale 1ns / 1ps

module multichannel_conv2d_accumulate_unit_test;
  import mcconv_pkg::*;

  localparam int IMG_PIXELS    = IMG_DIM_DEF * IMG_DIM_DEF;
  localparam int NUM_WEIGHTS   = MAX_CH_DEF * KSIZE_DEF * KSIZE_DEF;
  localparam int SETTLE_CYCLES = 12;
  localparam int END_CYCLES    = 20;
  localparam int STALL_LIMIT   = 5000;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_cmd;
  logic [WIDX_W-1:0]       in_weight_index;
  logic signed [DW-1:0]    in_data;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [SUM_W-1:0] out_sum;
  logic [POS_W-1:0]        out_row;
  logic [POS_W-1:0]        out_col;
  logic                    out_last;
  logic                    cfg_we;
  logic [CFG_W-1:0]        cfg_wdata;

  int mismatches;
  int sums_pending;
  int items_taken;
  int sums_checked;
  int burst_left;
  bit steady;
  int quiet_cycles;

  multichannel_conv2d_accumulate_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_weight_index (in_weight_index),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sum         (out_sum),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  window_sum_checker sum_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_weight_index (in_weight_index),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sum         (out_sum),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatches),
    .sums_pending    (sums_pending),
    .items_taken     (items_taken),
    .sums_checked    (sums_checked)
  );

  always #5 clk = ~clk;

  // Q8.8 value biased toward the extremes, zero and values near one
  function automatic logic signed [DW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(DW-1){1'b0}}};
      1:       return {1'b0, {(DW-1){1'b1}}};
      2:       return '0;
      3:       return DW'(int'($urandom_range(0, 512)) - 256);
      default: return DW'($urandom);
    endcase
  endfunction

  // one item in bursts; entered and left at a falling edge
  task automatic send_item(input logic cmd, input logic [WIDX_W-1:0] widx,
                           input logic signed [DW-1:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_weight_index <= widx;
    in_data <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid, let every owed sum drain and the pipeline empty
  task automatic wait_idle(input int extra);
    in_valid <= 1'b0;
    burst_left = 0;
    while (sums_pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_channels(input logic [CFG_W-1:0] value);
    wait_idle(SETTLE_CYCLES);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random weight overwrites, out-of-range indexes included
  task automatic reload_weights(input int count);
    repeat (count) send_item(CMD_WEIGHT, WIDX_W'($urandom_range(0, 127)), pick_value());
  endtask

  // whole images in raster order, with the odd weight load slipped in
  task automatic send_images(input int count);
    repeat (count * IMG_PIXELS) begin
      if ($urandom_range(0, 31) == 0)
        send_item(CMD_WEIGHT, WIDX_W'($urandom_range(0, 127)), pick_value());
      send_item(CMD_PIXEL, WIDX_W'($urandom), pick_value());
    end
  endtask

  // receiver stalls in spans of changing style
  initial begin
    int span;
    int mode;
    out_ready = 1'b0;
    span = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 200);
      end
      span--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // watchdog on cycles where nothing moves on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_WEIGHT;
    in_weight_index = '0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    burst_left = 0;
    steady = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // weight indexes past the store must not land anywhere
    send_item(CMD_WEIGHT, WIDX_W'(NUM_WEIGHTS), {1'b0, {(DW-1){1'b1}}});
    send_item(CMD_WEIGHT, '1, {1'b1, {(DW-1){1'b0}}});
    send_item(CMD_WEIGHT, WIDX_W'($urandom_range(NUM_WEIGHTS + 1, 126)), pick_value());

    // load every weight, extremes at both ends of the store
    for (int i = 0; i < NUM_WEIGHTS; i++) begin
      if (i == 0) send_item(CMD_WEIGHT, WIDX_W'(i), {1'b1, {(DW-1){1'b0}}});
      else if (i == NUM_WEIGHTS - 1) send_item(CMD_WEIGHT, WIDX_W'(i), {1'b0, {(DW-1){1'b1}}});
      else send_item(CMD_WEIGHT, WIDX_W'(i), pick_value());
    end

    // single channel map
    write_channels(CFG_W'(1));
    send_images(1);

    // all four channels, first half with no sender gaps
    reload_weights(20);
    write_channels(CFG_W'(MAX_CH_DEF));
    steady = 1'b1;
    send_images(2);
    steady = 1'b0;
    send_images(2);

    // count above the maximum, then lowered to zero while on the second channel
    reload_weights(20);
    write_channels(CFG_W'(6));
    send_images(1);
    write_channels(CFG_W'(0));
    send_images(1);

    wait_idle(END_CYCLES);
    $display("covered %0d input items and %0d window sums over channel counts 1, 4, 6 and 0",
             items_taken, sums_checked);
    $display("with out-of-range weight indexes and a channel count lowered mid-stream");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
